FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They compile away when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/core/ars_pkg.sv
// ----------------------------------------------------------------------------
// ars_pkg
// Types and constants of the advertising report field scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ars_pkg;

   localparam int IDX_W = 8;
   localparam int END_W = 9;

   localparam logic [31:0] HASH_BASIS = 32'h811C_9DC5;
   localparam logic [31:0] HASH_PRIME = 32'd16777619;
   localparam logic [7:0]  MAKER_TYPE = 8'hFF;
   localparam logic [7:0]  MAKER_MIN_SIZE = 8'd3;

   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_EMPTY = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic       last_byte;
   } ars_req_type;

   typedef struct packed {
      logic [31:0] payload_hash;
      logic [15:0] company_id;
      logic        company_found;
      logic [6:0]  payload_length;
      logic        was_truncated;
      logic [31:0] change_count;
      logic [31:0] report_count;
   } ars_rsp_type;

   typedef struct packed {
      logic        found;
      logic [15:0] id;
   } ars_walk_type;

endpackage

FILE: rtl/core/ars_hash_unit.sv
// ----------------------------------------------------------------------------
// ars_hash_unit
// Running FNV-1a hash over the kept payload bytes of one report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ars_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        clear,
   input  logic [7:0]  data_byte,
   output logic [31:0] hash_next
);
   import ars_pkg::*;

   logic [31:0] running_hash_ff;
   logic [31:0] running_hash_in;

   always_comb begin
      running_hash_in = running_hash_ff;
      if (step) begin
         running_hash_in = (running_hash_ff ^ {24'd0, data_byte}) * HASH_PRIME;
      end
   end

   assign hash_next = running_hash_in;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         running_hash_ff <= HASH_BASIS;
      end else begin
         running_hash_ff <= running_hash_in;
      end
   end

endmodule

FILE: rtl/core/ars_field_walker.sv
// ----------------------------------------------------------------------------
// ars_field_walker
// Walks the length-type-value fields of a report and captures the company
// identifier of the first complete manufacturer field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ars_field_walker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     clear,
   input  logic [ars_pkg::IDX_W-1:0] pos,
   input  logic [7:0]               data_byte,
   output ars_pkg::ars_walk_type    status_next
);
   import ars_pkg::*;

   logic [IDX_W-1:0] field_head_ff, field_head_in;
   logic [END_W-1:0] field_end_ff, field_end_in;
   logic [7:0]       field_size_ff, field_size_in;
   logic             maker_field_ff, maker_field_in;
   logic [7:0]       id_low_byte_ff, id_low_byte_in;
   logic             walk_stopped_ff, walk_stopped_in;
   logic             found_flag_ff, found_flag_in;
   logic [15:0]      found_id_ff, found_id_in;

   logic [END_W-1:0] pos_w;
   logic [END_W-1:0] head_w;
   logic             at_head;

   assign pos_w   = {1'b0, pos};
   assign head_w  = {1'b0, field_head_ff};
   assign at_head = (pos == field_head_ff);

   always_comb begin
      field_head_in   = field_head_ff;
      field_end_in    = field_end_ff;
      field_size_in   = field_size_ff;
      maker_field_in  = maker_field_ff;
      id_low_byte_in  = id_low_byte_ff;
      walk_stopped_in = walk_stopped_ff;
      found_flag_in   = found_flag_ff;
      found_id_in     = found_id_ff;
      if (step && !walk_stopped_ff && !found_flag_ff) begin
         if (at_head) begin
            if (data_byte == 8'd0) begin
               walk_stopped_in = 1'b1;
            end else begin
               field_size_in  = data_byte;
               field_end_in   = pos_w + {1'b0, data_byte} + END_W'(1);
               maker_field_in = 1'b0;
            end
         end else if (pos_w == head_w + END_W'(1)) begin
            maker_field_in = (data_byte == MAKER_TYPE) && (field_size_ff >= MAKER_MIN_SIZE);
         end else if (pos_w == head_w + END_W'(2)) begin
            if (maker_field_ff) begin
               id_low_byte_in = data_byte;
            end
         end else if (pos_w == head_w + END_W'(3)) begin
            if (maker_field_ff) begin
               found_id_in = {data_byte, id_low_byte_ff};
            end
         end
         if (!(at_head && data_byte == 8'd0) && (pos_w + END_W'(1) == field_end_in)) begin
            if (maker_field_in) begin
               found_flag_in = 1'b1;
            end else begin
               field_head_in = field_end_in[IDX_W-1:0];
            end
         end
      end
   end

   assign status_next.found = found_flag_in;
   assign status_next.id    = found_id_in;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         field_head_ff   <= '0;
         field_end_ff    <= '0;
         field_size_ff   <= '0;
         maker_field_ff  <= 1'b0;
         id_low_byte_ff  <= '0;
         walk_stopped_ff <= 1'b0;
         found_flag_ff   <= 1'b0;
         found_id_ff     <= '0;
      end else begin
         field_head_ff   <= field_head_in;
         field_end_ff    <= field_end_in;
         field_size_ff   <= field_size_in;
         maker_field_ff  <= maker_field_in;
         id_low_byte_ff  <= id_low_byte_in;
         walk_stopped_ff <= walk_stopped_in;
         found_flag_ff   <= found_flag_in;
         found_id_ff     <= found_id_in;
      end
   end

endmodule

FILE: rtl/core/ars_out_buffer.sv
// ----------------------------------------------------------------------------
// ars_out_buffer
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ars_out_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ars_pkg::ars_rsp_type push_data,
   output logic                 space,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ars_pkg::ars_rsp_type rsp_payload
);
   import ars_pkg::*;

   logic        out_valid_ff;
   logic        skid_valid_ff;
   ars_rsp_type out_ff;
   ars_rsp_type skid_ff;
   logic        pop;

   assign pop         = out_valid_ff && rsp_ready;
   assign space       = !skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
            out_ff       <= push_data;
         end
      end else if (!out_valid_ff) begin
         out_valid_ff <= push;
         out_ff       <= push_data;
      end else if (push) begin
         skid_ff       <= push_data;
         skid_valid_ff <= 1'b1;
      end
   end

   `ASSERT_ALWAYS(a_skid_needs_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid holds a result while the output register is empty")
   `ASSERT_IMPLY(a_no_push_when_full, clock, reset, push, !skid_valid_ff, "result pushed into a full buffer")
   `ASSERT_NEXT(a_stall_fills_skid, clock, reset, push && out_valid_ff && !rsp_ready, skid_valid_ff, "stalled result was not kept in the skid register")

endmodule

FILE: rtl/core/adv_report_field_scanner_unit.sv
// ----------------------------------------------------------------------------
// adv_report_field_scanner_unit
// Advertising report scanner: payload hash, manufacturer company ID and
// running report and change counters.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one payload byte per transfer (op byte) or a
// complete empty report (op empty). last_byte on a byte transfer ends the
// report. Every report end produces one transfer on the rsp channel with the
// hash, company ID, kept length, truncation flag and both running counters.
// Bytes beyond MAX_BYTES only set the truncation flag.
// Throughput is one req transfer per cycle while req_ready is high; each byte
// is hashed and walked in the cycle of its transfer. A report's result reaches
// rsp through the output register, or through the skid register when stalled.
// The result side is a two-entry buffer. When the receiver stalls, req_ready
// stays high until both entries hold results, so one more report can finish
// behind a waiting result.
// Reset clears the report in progress, the previous hash and both counters,
// and empties the result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module adv_report_field_scanner_unit #(
   parameter int MAX_BYTES = 96
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ars_pkg::ars_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ars_pkg::ars_rsp_type rsp_payload
);
   import ars_pkg::*;

   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BYTES);

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic             over_cap_ff, over_cap_in;
   logic [31:0]      previous_hash_ff, previous_hash_in;
   logic             seen_before_ff;
   logic [31:0]      changes_ff, changes_in;
   logic [31:0]      reports_ff, reports_in;

   logic             accept;
   logic             is_byte;
   logic             kept;
   logic             report_end;
   logic [31:0]      hash_next;
   logic [31:0]      hash_result;
   logic             changed;
   ars_walk_type     walk_next;
   ars_rsp_type      result;
   logic             space;

   assign req_ready  = space;
   assign accept     = req_valid && space;
   assign is_byte    = (req_payload.op == OP_BYTE);
   assign kept       = accept && is_byte && (byte_index_ff < MAX_IDX);
   assign report_end = accept && (!is_byte || req_payload.last_byte);

   ars_hash_unit u_hash (
      .clock     (clock),
      .reset     (reset),
      .step      (kept),
      .clear     (report_end),
      .data_byte (req_payload.data_byte),
      .hash_next (hash_next)
   );

   ars_field_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .step        (kept),
      .clear       (report_end),
      .pos         (byte_index_ff),
      .data_byte   (req_payload.data_byte),
      .status_next (walk_next)
   );

   always_comb begin
      byte_index_in = byte_index_ff;
      over_cap_in   = over_cap_ff;
      if (kept) begin
         byte_index_in = byte_index_ff + IDX_W'(1);
      end else if (accept && is_byte) begin
         over_cap_in = 1'b1;
      end
      hash_result = (is_byte && byte_index_in != '0) ? hash_next : 32'd0;
      changed = seen_before_ff && (hash_result != 32'd0) && (previous_hash_ff != 32'd0)
                && (hash_result != previous_hash_ff);
      changes_in       = changes_ff + {31'd0, changed};
      reports_in       = reports_ff + 32'd1;
      previous_hash_in = hash_result;

      result.payload_hash   = hash_result;
      result.company_found  = is_byte && walk_next.found;
      result.company_id     = result.company_found ? walk_next.id : 16'd0;
      result.payload_length = is_byte ? byte_index_in[6:0] : 7'd0;
      result.was_truncated  = is_byte && over_cap_in;
      result.change_count   = changes_in;
      result.report_count   = reports_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff    <= '0;
         over_cap_ff      <= 1'b0;
         previous_hash_ff <= '0;
         seen_before_ff   <= 1'b0;
         changes_ff       <= '0;
         reports_ff       <= '0;
      end else if (report_end) begin
         byte_index_ff    <= '0;
         over_cap_ff      <= 1'b0;
         previous_hash_ff <= previous_hash_in;
         seen_before_ff   <= 1'b1;
         changes_ff       <= changes_in;
         reports_ff       <= reports_in;
      end else begin
         byte_index_ff <= byte_index_in;
         over_cap_ff   <= over_cap_in;
      end
   end

   ars_out_buffer u_out (
      .clock       (clock),
      .reset       (reset),
      .push        (report_end),
      .push_data   (result),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   `ASSERT_ALWAYS(a_index_in_range, clock, reset, byte_index_ff <= MAX_IDX, "byte index ran past the byte cap")
   `ASSERT_NEXT(a_report_counted, clock, reset, report_end, reports_ff == $past(reports_ff) + 32'd1, "report end did not advance the report counter")
   `ASSERT_NEXT(a_report_to_rsp, clock, reset, report_end, rsp_valid, "report end did not present a result")

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the advertising report field scanner. A scoreboard
// in the bench tracks the hash, the field walk and the running counters of
// each report and queues the summary expected at every report end. The
// directed cases cover empty and single-byte reports, manufacturer fields,
// the walk stop, incomplete fields and the byte cap. One long receiver hold
// follows; then random reports of well-formed fields, noise and aborted
// reports run first with no gaps and then with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import ars_pkg::*;

   localparam int MAX_KEPT = 96;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_TRANSFERS = 300;
   localparam int REPORT_LIMIT = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ars_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ars_rsp_type rsp_payload;

   adv_report_field_scanner_unit #(.MAX_BYTES(MAX_KEPT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scoreboard state of the report in progress and of the running counters.
   logic [7:0]  kept_count;
   logic [8:0]  field_start;
   logic [8:0]  field_stop;
   logic [7:0]  field_len;
   logic        maker_seen;
   logic [7:0]  company_low;
   logic        walk_done;
   logic        company_seen;
   logic [15:0] company_value;
   logic [31:0] hash_acc;
   logic        overflow;
   logic [31:0] last_hash;
   logic        had_report;
   logic [31:0] change_total;
   logic [31:0] report_total;

   ars_rsp_type expected_summaries[$];
   logic [7:0]  payload_bytes[$];

   int error_count = 0;
   int summaries_checked = 0;
   int transfers_sent = 0;
   int hold_cycles = 0;
   bit idling_on = 1'b1;

   function automatic void append_byte(logic [7:0] value);
      payload_bytes.insert(payload_bytes.size(), value);
   endfunction

   function automatic void clear_report_state();
      kept_count = 8'd0;
      field_start = 9'd0;
      field_stop = 9'd0;
      field_len = 8'd0;
      maker_seen = 1'b0;
      company_low = 8'd0;
      walk_done = 1'b0;
      company_seen = 1'b0;
      company_value = 16'd0;
      hash_acc = HASH_BASIS;
      overflow = 1'b0;
   endfunction

   function automatic void reset_scanner_state();
      clear_report_state();
      last_hash = 32'd0;
      had_report = 1'b0;
      change_total = 32'd0;
      report_total = 32'd0;
   endfunction

   function automatic void walk_field_byte(logic [8:0] pos, logic [7:0] value);
      if (walk_done || company_seen) return;
      if (pos == field_start) begin
         if (value == 8'd0) begin
            walk_done = 1'b1;
            return;
         end
         field_len = value;
         field_stop = pos + {1'b0, value} + 9'd1;
         maker_seen = 1'b0;
      end else if (pos == field_start + 9'd1) begin
         maker_seen = (value == MAKER_TYPE) && (field_len >= MAKER_MIN_SIZE);
      end else if (pos == field_start + 9'd2) begin
         if (maker_seen) company_low = value;
      end else if (pos == field_start + 9'd3) begin
         if (maker_seen) company_value = {value, company_low};
      end
      if (pos + 9'd1 == field_stop) begin
         if (maker_seen) company_seen = 1'b1;
         else field_start = field_stop;
      end
   endfunction

   function automatic void close_report();
      ars_rsp_type summary;
      logic [31:0] hash_now;
      hash_now = (kept_count != 8'd0) ? hash_acc : 32'd0;
      if (had_report && hash_now != 32'd0 && last_hash != 32'd0 && hash_now != last_hash)
         change_total = change_total + 32'd1;
      last_hash = hash_now;
      report_total = report_total + 32'd1;
      had_report = 1'b1;
      summary.payload_hash = hash_now;
      summary.company_id = company_seen ? company_value : 16'd0;
      summary.company_found = company_seen;
      summary.payload_length = kept_count[6:0];
      summary.was_truncated = overflow;
      summary.change_count = change_total;
      summary.report_count = report_total;
      expected_summaries.insert(expected_summaries.size(), summary);
      clear_report_state();
   endfunction

   function automatic void scan_transfer(ars_req_type xfer);
      if (xfer.op == OP_EMPTY) begin
         clear_report_state();
         close_report();
      end else begin
         if (kept_count < 8'(MAX_KEPT)) begin
            hash_acc = (hash_acc ^ {24'd0, xfer.data_byte}) * HASH_PRIME;
            walk_field_byte({1'b0, kept_count}, xfer.data_byte);
            kept_count = kept_count + 8'd1;
         end else begin
            overflow = 1'b1;
         end
         if (xfer.last_byte) close_report();
      end
   endfunction

   function automatic void note_failure(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endfunction

   function automatic void check_field(string field_name, logic [31:0] want,
                                       logic [31:0] got);
      if (got !== want)
         note_failure($sformatf("summary %0d %s: expected %0h, actual %0h",
                                summaries_checked, field_name, want, got));
   endfunction

   always @(posedge clock) begin
      ars_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_summaries.size() == 0) begin
            note_failure($sformatf("unexpected summary transfer, hash %0h",
                                   rsp_payload.payload_hash));
         end else begin
            want = expected_summaries.pop_front();
            check_field("payload_hash", want.payload_hash, rsp_payload.payload_hash);
            check_field("company_id", 32'(want.company_id),
                        32'(rsp_payload.company_id));
            check_field("company_found", 32'(want.company_found),
                        32'(rsp_payload.company_found));
            check_field("payload_length", 32'(want.payload_length),
                        32'(rsp_payload.payload_length));
            check_field("was_truncated", 32'(want.was_truncated),
                        32'(rsp_payload.was_truncated));
            check_field("change_count", want.change_count, rsp_payload.change_count);
            check_field("report_count", want.report_count, rsp_payload.report_count);
         end
         summaries_checked++;
      end
   end

   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= !(idling_on && $urandom_range(99) < 16);
      end
   end

   task automatic send_transfer(input logic op, input logic [7:0] data,
                                input logic last_flag);
      ars_req_type xfer;
      xfer.op = op;
      xfer.data_byte = data;
      xfer.last_byte = last_flag;
      if (idling_on) begin
         while ($urandom_range(99) < 16) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_payload <= xfer;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scan_transfer(xfer);
      transfers_sent++;
   endtask

   task automatic send_payload(input bit close_report_flag);
      for (int i = 0; i < payload_bytes.size(); i++)
         send_transfer(OP_BYTE, payload_bytes[i],
                       close_report_flag && (i == payload_bytes.size() - 1));
   endtask

   task automatic build_noise_payload(input int count);
      payload_bytes.delete();
      repeat (count) append_byte(8'($urandom_range(255)));
   endtask

   task automatic build_field_payload(input int target);
      int len;
      payload_bytes.delete();
      while (payload_bytes.size() < target) begin
         if ($urandom_range(99) < 4) append_byte(8'd0);
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         append_byte(8'(len));
         if ($urandom_range(99) < 40) append_byte(MAKER_TYPE);
         else append_byte(8'($urandom_range(255)));
         for (int k = 1; k < len; k++) append_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 40) begin
         while (payload_bytes.size() > target) void'(payload_bytes.pop_back());
      end
   endtask

   task automatic test_directed_cases();
      send_transfer(OP_EMPTY, 8'hFF, 1'b1);
      send_transfer(OP_EMPTY, 8'h00, 1'b0);
      send_transfer(OP_BYTE, 8'h00, 1'b1);
      send_transfer(OP_BYTE, 8'hFF, 1'b1);
      send_transfer(OP_BYTE, 8'hFF, 1'b1);
      payload_bytes = '{8'h05, 8'hFF, 8'h34, 8'h12, 8'hAB, 8'hCD};
      send_payload(1'b1);
      payload_bytes = '{8'h02, 8'h01, 8'h06, 8'h03, 8'hFF, 8'h4C, 8'h00};
      send_payload(1'b1);
      payload_bytes = '{8'h04, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_payload(1'b1);
      payload_bytes = '{8'h02, 8'hFF, 8'h11, 8'h04, 8'hFF, 8'h22, 8'h33, 8'h44};
      send_payload(1'b1);
      payload_bytes = '{8'h01, 8'hFF, 8'h03, 8'hFF, 8'h77, 8'h88};
      send_payload(1'b1);
      payload_bytes = '{8'h00, 8'h04, 8'hFF, 8'h01, 8'h02, 8'h03};
      send_payload(1'b1);
      payload_bytes = '{8'h07, 8'hFF, 8'h01, 8'h02};
      send_payload(1'b1);
      payload_bytes = '{8'h03, 8'hFF, 8'h01};
      send_payload(1'b1);
      // A manufacturer field that ends exactly on the last kept byte.
      payload_bytes.delete();
      append_byte(8'd91);
      append_byte(8'h09);
      repeat (90) append_byte(8'($urandom_range(255)));
      append_byte(8'h03);
      append_byte(MAKER_TYPE);
      append_byte(8'hAA);
      append_byte(8'h55);
      send_payload(1'b1);
      append_byte(8'h5A);
      send_payload(1'b1);
      build_noise_payload(130);
      send_payload(1'b1);
      payload_bytes = '{8'h03, 8'hFF, 8'h12};
      send_payload(1'b0);
      send_transfer(OP_EMPTY, 8'h3C, 1'b1);
   endtask

   task automatic run_random_reports(input int transfers);
      int stop_at;
      int mode;
      int cut;
      stop_at = transfers_sent + transfers;
      while (transfers_sent < stop_at) begin
         mode = $urandom_range(99);
         if (mode < 60) begin
            build_field_payload($urandom_range(1, 31));
            send_payload(1'b1);
         end else if (mode < 70 && payload_bytes.size() != 0) begin
            send_payload(1'b1);
         end else if (mode < 78) begin
            build_noise_payload($urandom_range(1, 20));
            send_payload(1'b1);
         end else if (mode < 86) begin
            send_transfer(OP_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (mode < 94) begin
            build_field_payload($urandom_range(2, 20));
            cut = $urandom_range(1, payload_bytes.size() - 1);
            while (payload_bytes.size() > cut) void'(payload_bytes.pop_back());
            send_payload(1'b0);
            send_transfer(OP_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            build_field_payload($urandom_range(90, 110));
            send_payload(1'b1);
         end
      end
   endtask

   task automatic test_receiver_hold();
      hold_cycles <= HOLD_CYCLES;
      repeat (40) send_transfer(OP_BYTE, 8'($urandom_range(255)), 1'b1);
   endtask

   task automatic test_quiet_stretch();
      idling_on = 1'b0;
      run_random_reports(300);
      idling_on = 1'b1;
   endtask

   task automatic test_random_reports();
      run_random_reports(RANDOM_TRANSFERS);
   endtask

   initial begin
      reset_scanner_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_receiver_hold();
      test_quiet_stretch();
      test_random_reports();
      req_valid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ars_pkg.sv
rtl/core/ars_hash_unit.sv
rtl/core/ars_field_walker.sv
rtl/core/ars_out_buffer.sv
rtl/core/adv_report_field_scanner_unit.sv
bench/tb_top.sv
